// ----- rtl/mie_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

  // Data memory geometry. The depth is a power of two so the address wraps by masking.
  localparam int DATA_WORDS = 256;
  localparam int DM_AW      = $clog2(DATA_WORDS);

  // Register file geometry.
  localparam int RF_DEPTH = 16;
  localparam int RF_AW    = $clog2(RF_DEPTH);

  // Number of opcodes that keep an execution counter.
  localparam int NUM_OPS = 15;

  // Opcode values, bits 27:24 of the instruction word.
  localparam logic [3:0] OP_ADD     = 4'd0;
  localparam logic [3:0] OP_SUB     = 4'd1;
  localparam logic [3:0] OP_SLT     = 4'd2;
  localparam logic [3:0] OP_OR      = 4'd3;
  localparam logic [3:0] OP_NAND    = 4'd4;
  localparam logic [3:0] OP_ADDI    = 4'd5;
  localparam logic [3:0] OP_SLTI    = 4'd6;
  localparam logic [3:0] OP_ORI     = 4'd7;
  localparam logic [3:0] OP_LUI     = 4'd8;
  localparam logic [3:0] OP_LW      = 4'd9;
  localparam logic [3:0] OP_SW      = 4'd10;
  localparam logic [3:0] OP_BEQ     = 4'd11;
  localparam logic [3:0] OP_JALR    = 4'd12;
  localparam logic [3:0] OP_J       = 4'd13;
  localparam logic [3:0] OP_HALT    = 4'd14;
  localparam logic [3:0] OP_ILLEGAL = 4'd15;

  // Program counter value left by a halt.
  localparam logic [31:0] HALT_PC = 32'hFFFF_FFFF;

  // Decoded fields of one instruction word.
  typedef struct packed {
    logic [3:0]       op;
    logic [RF_AW-1:0] rs;
    logic [RF_AW-1:0] rt;
    logic [RF_AW-1:0] rd;
    logic [15:0]      off;
  } instr_t;

  function automatic instr_t decode(input logic [31:0] w);
    instr_t d;
    d.op  = w[27:24];
    d.rs  = w[23:20];
    d.rt  = w[19:16];
    d.rd  = w[15:12];
    d.off = w[15:0];
    return d;
  endfunction

  // Opcodes that write a register.
  function automatic logic writes_reg(input logic [3:0] op);
    return (op <= OP_LW) || (op == OP_JALR);
  endfunction

  // Destination register: rd for the three-register forms, rt otherwise.
  function automatic logic [RF_AW-1:0] dest_reg(input instr_t d);
    return (d.op <= OP_NAND) ? d.rd : d.rt;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mini_isa_instruction_executor.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Executes one 32-bit instruction word per clock, unless stalled, on a 16 x 32 register
// file, a DATA_WORDS x 32 data memory, a program counter and per-opcode counters, and
// returns one result word per instruction, in order. Three stages: the register file
// is read as the word is accepted, the address stage forms the load/store address and
// reads the data memory, and the execute stage executes, commits and loads the output
// register. One word is taken every cycle while the output is not stalled; the
// exception is a lw or sw whose base register is written by the instruction just ahead
// of it, which waits in the address stage until that instruction commits, because the
// address adder needs that value before the data memory read. Both memories read as
// zero after reset through per-entry valid bits, so no clearing pass is needed. After
// a halt, every later word is answered with the halted state.
module mini_isa_instruction_executor
  import mie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_instruction_word,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_next_pc,
  output logic             out_halted,
  output logic             out_illegal_op,
  output logic             out_reg_write,
  output logic [3:0]       out_write_reg,
  output logic [31:0]      out_write_value,
  output logic             out_mem_write,
  output logic [7:0]       out_mem_address,
  output logic [31:0]      out_op_count,
  output logic [31:0]      out_executed_count
);

  // Storage.
  logic [31:0]         rf_mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] rf_vld_r;
  logic [31:0]         dm_mem [DATA_WORDS];
  logic [DATA_WORDS-1:0] dm_vld_r;

  // Architectural registers.
  logic [31:0] pc_r;
  logic        halt_r;
  logic [31:0] cnt_r [NUM_OPS];
  logic [31:0] total_r;

  // Address stage.
  logic        a_valid_r;
  logic [31:0] a_word_r;
  logic [31:0] rf_rd_a_r, rf_rd_b_r;
  logic        rf_rd_a_v_r, rf_rd_b_v_r;
  logic        a_byp_a_v_r, a_byp_b_v_r;
  logic [31:0] a_byp_a_r, a_byp_b_r;

  // Execute stage.
  logic             b_valid_r;
  logic [31:0]      b_word_r;
  logic [31:0]      b_a_r, b_b_r;
  logic [DM_AW-1:0] b_addr_r;
  logic [31:0]      dm_rd_r;
  logic             dm_rd_v_r;
  logic             dm_byp_v_r;
  logic [31:0]      dm_byp_r;

  // Output register.
  logic out_valid_r;

  instr_t in_d, a_d, b_d;
  logic   accept, a_move, b_move, hazard;

  assign in_d = decode(in_instruction_word);
  assign a_d  = decode(a_word_r);
  assign b_d  = decode(b_word_r);

  // Flow control: stages advance when the next is free or moving; a hazard holds lw/sw.
  assign b_move   = b_valid_r && (!out_valid_r || !out_stall);
  assign hazard   = a_valid_r && ((a_d.op == OP_LW) || (a_d.op == OP_SW)) &&
                    b_valid_r && writes_reg(b_d.op) && (dest_reg(b_d) == a_d.rs);
  assign a_move   = a_valid_r && !hazard && (!b_valid_r || b_move);
  assign in_stall = a_valid_r && !a_move;
  assign accept   = in_valid && !in_stall;

  // Execute stage: result of the instruction at the end of the pipe.
  logic        ex_live, ex_rw, ex_mw, ex_halt;
  logic [RF_AW-1:0] ex_wr;
  logic [31:0] ex_wv, ex_npc, ex_pc1, ex_off, dm_data, cnt_cur, cnt_new;
  logic [31:0] b_addr_ext;

  assign ex_off     = {16'b0, b_d.off};
  assign ex_pc1     = pc_r + 32'd1;
  assign dm_data    = dm_byp_v_r ? dm_byp_r : (dm_rd_v_r ? dm_rd_r : 32'd0);
  assign b_addr_ext = {{(32 - DM_AW){1'b0}}, b_addr_r};
  assign ex_live    = !halt_r && (b_d.op != OP_ILLEGAL);
  assign cnt_cur    = (b_d.op != OP_ILLEGAL) ? cnt_r[b_d.op] : 32'd0;
  assign cnt_new    = cnt_cur + 32'd1;

  always_comb begin
    ex_npc  = ex_pc1;
    ex_rw   = 1'b0;
    ex_wr   = '0;
    ex_wv   = 32'd0;
    ex_mw   = 1'b0;
    ex_halt = 1'b0;
    if (!ex_live) begin
      ex_npc = pc_r;
    end else begin
      case (b_d.op)
        OP_ADD: begin
          ex_rw = 1'b1; ex_wr = b_d.rd; ex_wv = b_a_r + b_b_r;
        end
        OP_SUB: begin
          ex_rw = 1'b1; ex_wr = b_d.rd; ex_wv = b_a_r - b_b_r;
        end
        OP_SLT: begin
          ex_rw = 1'b1; ex_wr = b_d.rd;
          ex_wv = {31'b0, $signed(b_a_r) < $signed(b_b_r)};
        end
        OP_OR: begin
          ex_rw = 1'b1; ex_wr = b_d.rd; ex_wv = b_a_r | b_b_r;
        end
        OP_NAND: begin
          ex_rw = 1'b1; ex_wr = b_d.rd; ex_wv = ~(b_a_r & b_b_r);
        end
        OP_ADDI: begin
          ex_rw = 1'b1; ex_wr = b_d.rt; ex_wv = b_a_r + ex_off;
        end
        OP_SLTI: begin
          ex_rw = 1'b1; ex_wr = b_d.rt;
          ex_wv = {31'b0, $signed(b_a_r) < $signed(ex_off)};
        end
        OP_ORI: begin
          ex_rw = 1'b1; ex_wr = b_d.rt; ex_wv = b_a_r | ex_off;
        end
        OP_LUI: begin
          ex_rw = 1'b1; ex_wr = b_d.rt; ex_wv = {b_d.off, 16'b0};
        end
        OP_LW: begin
          ex_rw = 1'b1; ex_wr = b_d.rt; ex_wv = dm_data;
        end
        OP_SW: begin
          ex_mw = 1'b1; ex_wv = b_b_r;
        end
        OP_BEQ: begin
          if (b_a_r == b_b_r) begin
            ex_npc = ex_pc1 + ex_off;
          end
        end
        OP_JALR: begin
          // The link is written before rs is read, so rs == rt jumps to pc + 1.
          ex_rw  = 1'b1; ex_wr = b_d.rt; ex_wv = ex_pc1;
          ex_npc = (b_d.rs == b_d.rt) ? ex_pc1 : b_a_r;
        end
        OP_J: begin
          ex_npc = ex_off;
        end
        default: begin
          ex_npc  = HALT_PC;
          ex_halt = 1'b1;
        end
      endcase
    end
  end

  logic rf_we, dm_we;
  assign rf_we = b_move && ex_rw;
  assign dm_we = b_move && ex_mw;

  // Address stage operands, with writes committed since the register read merged in.
  logic [31:0]      a_opa, a_opb, a_sum;
  logic [DM_AW-1:0] a_addr;

  assign a_opa  = a_byp_a_v_r ? a_byp_a_r : (rf_rd_a_v_r ? rf_rd_a_r : 32'd0);
  assign a_opb  = a_byp_b_v_r ? a_byp_b_r : (rf_rd_b_v_r ? rf_rd_b_r : 32'd0);
  assign a_sum  = a_opa + {16'b0, a_d.off};
  assign a_addr = a_sum[DM_AW-1:0];

  // Register file: one write port, two read ports registered at accept.
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[ex_wr] <= ex_wv;
    end
    if (accept) begin
      rf_rd_a_r   <= rf_mem[in_d.rs];
      rf_rd_b_r   <= rf_mem[in_d.rt];
      rf_rd_a_v_r <= rf_vld_r[in_d.rs];
      rf_rd_b_v_r <= rf_vld_r[in_d.rt];
    end
  end

  // Data memory: one write port, one read port registered as the address stage moves.
  always_ff @(posedge clk) begin
    if (dm_we) begin
      dm_mem[b_addr_r] <= b_b_r;
    end
    if (a_move) begin
      dm_rd_r   <= dm_mem[a_addr];
      dm_rd_v_r <= dm_vld_r[a_addr];
    end
  end

  // Valid bits make never-written entries read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      dm_vld_r <= '0;
    end else begin
      if (rf_we) begin
        rf_vld_r[ex_wr] <= 1'b1;
      end
      if (dm_we) begin
        dm_vld_r[b_addr_r] <= 1'b1;
      end
    end
  end

  // Capture register writes that land after the register file read of the
  // instruction now entering or waiting in the address stage.
  logic [RF_AW-1:0] tgt_rs, tgt_rt;
  assign tgt_rs = accept ? in_d.rs : a_d.rs;
  assign tgt_rt = accept ? in_d.rt : a_d.rt;

  always_ff @(posedge clk) begin
    if (rf_we && (ex_wr == tgt_rs)) begin
      a_byp_a_v_r <= 1'b1;
      a_byp_a_r   <= ex_wv;
    end else if (accept) begin
      a_byp_a_v_r <= 1'b0;
    end
    if (rf_we && (ex_wr == tgt_rt)) begin
      a_byp_b_v_r <= 1'b1;
      a_byp_b_r   <= ex_wv;
    end else if (accept) begin
      a_byp_b_v_r <= 1'b0;
    end
  end

  // Address stage to execute stage payload, forwarding a commit on the same edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_word_r <= in_instruction_word;
    end
    if (a_move) begin
      b_word_r   <= a_word_r;
      b_addr_r   <= a_addr;
      b_a_r      <= (rf_we && (ex_wr == a_d.rs)) ? ex_wv : a_opa;
      b_b_r      <= (rf_we && (ex_wr == a_d.rt)) ? ex_wv : a_opb;
      dm_byp_v_r <= dm_we && (b_addr_r == a_addr);
      dm_byp_r   <= b_b_r;
    end
  end

  // Pipeline valid flags and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= 32'd0;
      halt_r      <= 1'b0;
      total_r     <= 32'd0;
      for (int i = 0; i < NUM_OPS; i++) begin
        cnt_r[i] <= 32'd0;
      end
    end else begin
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (a_move) begin
        a_valid_r <= 1'b0;
      end
      if (a_move) begin
        b_valid_r <= 1'b1;
      end else if (b_move) begin
        b_valid_r <= 1'b0;
      end
      if (b_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (b_move && ex_live) begin
        pc_r           <= ex_npc;
        halt_r         <= halt_r | ex_halt;
        total_r        <= total_r + 32'd1;
        cnt_r[b_d.op]  <= cnt_new;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (b_move) begin
      out_next_pc        <= ex_npc;
      out_halted         <= halt_r | ex_halt;
      out_illegal_op     <= !halt_r && (b_d.op == OP_ILLEGAL);
      out_reg_write      <= ex_rw;
      out_write_reg      <= 4'(ex_wr);
      out_write_value    <= ex_wv;
      out_mem_write      <= ex_mw;
      out_mem_address    <= ((b_d.op == OP_LW) || (b_d.op == OP_SW)) && ex_live
                            ? b_addr_ext[7:0] : 8'd0;
      out_op_count       <= ex_live ? cnt_new : 32'd0;
      out_executed_count <= ex_live ? total_r + 32'd1 : total_r;
    end
  end

  assign out_valid = out_valid_r;

  // Once halted, nothing is committed to either memory.
  a_halt_no_commit: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> !(rf_we || dm_we))
    else $error("commit after halt");

  // A stalled execute stage is never overwritten by the address stage.
  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_move) |-> !a_move)
    else $error("execute stage overwritten while stalled");

  // Each executed instruction adds exactly one to the total count.
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    (b_move && ex_live) |=> (total_r == $past(total_r) + 32'd1))
    else $error("total count did not step");

  // An illegal opcode reports no register or memory write.
  a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_illegal_op) |-> !(out_reg_write || out_mem_write))
    else $error("illegal opcode reported a write");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

import mie_pkg::*;

// One result word as the block presents it on the output channel.
typedef struct packed {
  logic [31:0] next_pc;
  logic        halted;
  logic        illegal_op;
  logic        reg_write;
  logic [3:0]  write_reg;
  logic [31:0] write_value;
  logic        mem_write;
  logic [7:0]  mem_address;
  logic [31:0] op_count;
  logic [31:0] executed_count;
} exec_result_t;

// Architectural shadow of the executor plus the queue of results it still owes.
class exec_scoreboard;
  logic [31:0]  regs [RF_DEPTH];
  logic [31:0]  dmem [DATA_WORDS];
  logic [31:0]  op_counts [NUM_OPS];
  logic [31:0]  pc;
  logic [31:0]  total;
  bit           halt_seen;
  exec_result_t owed_q[$];
  int           mismatches;
  int           checked;

  function new();
    foreach (regs[i]) regs[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    foreach (op_counts[i]) op_counts[i] = '0;
    pc         = '0;
    total      = '0;
    halt_seen  = 1'b0;
    mismatches = 0;
    checked    = 0;
  endfunction

  task report(string msg);
    if (mismatches < 30) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function int pending();
    return owed_q.size();
  endfunction

  // Execute one accepted instruction word on the shadow state and queue its result.
  function void note_word(logic [31:0] w);
    exec_result_t r;
    logic [3:0]   op;
    logic [3:0]   rs;
    logic [3:0]   rt;
    logic [3:0]   rd;
    logic [31:0]  off;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  npc;
    logic [31:0]  addr;
    r   = '0;
    op  = w[27:24];
    rs  = w[23:20];
    rt  = w[19:16];
    rd  = w[15:12];
    off = {16'h0000, w[15:0]};
    a   = regs[rs];
    b   = regs[rt];
    npc = pc + 32'd1;

    if (halt_seen) begin
      // Once halted, every word just reports the frozen state.
      r.next_pc = pc;
      r.halted  = 1'b1;
    end else if (op == OP_ILLEGAL) begin
      r.illegal_op = 1'b1;
      r.next_pc    = pc;
    end else begin
      case (op)
        OP_ADD: begin
          r.reg_write = 1'b1; r.write_reg = rd; r.write_value = a + b;
        end
        OP_SUB: begin
          r.reg_write = 1'b1; r.write_reg = rd; r.write_value = a - b;
        end
        OP_SLT: begin
          r.reg_write = 1'b1; r.write_reg = rd;
          r.write_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        end
        OP_OR: begin
          r.reg_write = 1'b1; r.write_reg = rd; r.write_value = a | b;
        end
        OP_NAND: begin
          r.reg_write = 1'b1; r.write_reg = rd; r.write_value = ~(a & b);
        end
        OP_ADDI: begin
          r.reg_write = 1'b1; r.write_reg = rt; r.write_value = a + off;
        end
        OP_SLTI: begin
          r.reg_write = 1'b1; r.write_reg = rt;
          r.write_value = ($signed(a) < $signed(off)) ? 32'd1 : 32'd0;
        end
        OP_ORI: begin
          r.reg_write = 1'b1; r.write_reg = rt; r.write_value = a | off;
        end
        OP_LUI: begin
          r.reg_write = 1'b1; r.write_reg = rt; r.write_value = off << 16;
        end
        OP_LW: begin
          addr = (a + off) % DATA_WORDS;
          r.reg_write = 1'b1; r.write_reg = rt; r.write_value = dmem[addr];
          r.mem_address = addr[7:0];
        end
        OP_SW: begin
          addr = (a + off) % DATA_WORDS;
          r.mem_write = 1'b1; r.write_value = b; r.mem_address = addr[7:0];
          dmem[addr] = b;
        end
        OP_BEQ: begin
          if (a == b) npc = pc + 32'd1 + off;
        end
        OP_JALR: begin
          // The link is written before the target is read, so rs == rt lands on pc + 1.
          r.reg_write = 1'b1; r.write_reg = rt; r.write_value = pc + 32'd1;
          regs[rt] = pc + 32'd1;
          npc = regs[rs];
        end
        OP_J: npc = off;
        default: begin
          npc = HALT_PC;
          halt_seen = 1'b1;
        end
      endcase
      if (r.reg_write) regs[r.write_reg] = r.write_value;
      op_counts[op] = op_counts[op] + 32'd1;
      r.op_count    = op_counts[op];
      total         = total + 32'd1;
      pc            = npc;
      r.next_pc     = npc;
      r.halted      = halt_seen;
    end
    r.executed_count = total;
    owed_q.push_back(r);
  endfunction

  // Compare one delivered result with the oldest owed one, field by field.
  task check_result(exec_result_t got);
    exec_result_t exp;
    if (owed_q.size() == 0) begin
      report($sformatf("result with nothing owed, next_pc %h", got.next_pc));
    end else begin
      exp = owed_q.pop_front();
      checked++;
      if (got.next_pc !== exp.next_pc)
        report($sformatf("next_pc %h, want %h", got.next_pc, exp.next_pc));
      if (got.halted !== exp.halted)
        report($sformatf("halted %b, want %b", got.halted, exp.halted));
      if (got.illegal_op !== exp.illegal_op)
        report($sformatf("illegal_op %b, want %b", got.illegal_op, exp.illegal_op));
      if (got.reg_write !== exp.reg_write)
        report($sformatf("reg_write %b, want %b", got.reg_write, exp.reg_write));
      if (got.write_reg !== exp.write_reg)
        report($sformatf("write_reg %0d, want %0d", got.write_reg, exp.write_reg));
      if (got.write_value !== exp.write_value)
        report($sformatf("write_value %h, want %h", got.write_value, exp.write_value));
      if (got.mem_write !== exp.mem_write)
        report($sformatf("mem_write %b, want %b", got.mem_write, exp.mem_write));
      if (got.mem_address !== exp.mem_address)
        report($sformatf("mem_address %h, want %h", got.mem_address, exp.mem_address));
      if (got.op_count !== exp.op_count)
        report($sformatf("op_count %h, want %h", got.op_count, exp.op_count));
      if (got.executed_count !== exp.executed_count)
        report($sformatf("executed_count %h, want %h", got.executed_count,
                         exp.executed_count));
    end
  endtask
endclass

module tb;

  localparam int RESET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_WORDS = 680;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_instruction_word;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_next_pc;
  logic        out_halted;
  logic        out_illegal_op;
  logic        out_reg_write;
  logic [3:0]  out_write_reg;
  logic [31:0] out_write_value;
  logic        out_mem_write;
  logic [7:0]  out_mem_address;
  logic [31:0] out_op_count;
  logic [31:0] out_executed_count;

  exec_scoreboard sb;
  bit             quiet_tail;
  bit             hold_req;
  int             words_sent;
  int             idle_cycles;
  logic [3:0]     last_dest;

  mini_isa_instruction_executor dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_instruction_word(in_instruction_word),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_next_pc        (out_next_pc),
    .out_halted         (out_halted),
    .out_illegal_op     (out_illegal_op),
    .out_reg_write      (out_reg_write),
    .out_write_reg      (out_write_reg),
    .out_write_value    (out_write_value),
    .out_mem_write      (out_mem_write),
    .out_mem_address    (out_mem_address),
    .out_op_count       (out_op_count),
    .out_executed_count (out_executed_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one word and hold it until the block takes it.
  task send_word(logic [31:0] w);
    @(negedge clk);
    in_valid            <= 1'b1;
    in_instruction_word <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
    words_sent++;
  endtask

  // Drop valid and hold it low for a pause whose length is given by n.
  task pause_input(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Random instruction word, biased toward loads and stores that depend on the
  // register written just before, and toward taken branches.
  function automatic logic [31:0] random_word();
    logic [3:0]  op;
    logic [3:0]  rs;
    logic [3:0]  rt;
    logic [3:0]  rd;
    logic [15:0] off;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) op = OP_ILLEGAL;
    else if (pick < 16) op = OP_LW;
    else if (pick < 26) op = OP_SW;
    else op = 4'($urandom_range(0, 13));
    rs = 4'($urandom_range(0, 15));
    rt = 4'($urandom_range(0, 15));
    rd = 4'($urandom_range(0, 15));
    if ((op == OP_LW || op == OP_SW) && $urandom_range(0, 2) == 0) rs = last_dest;
    if (op == OP_BEQ && $urandom_range(0, 2) == 0) rt = rs;
    case ($urandom_range(0, 3))
      0: off = 16'($urandom_range(0, 15));
      1: off = 16'($urandom_range(0, 255));
      2: off = 16'($urandom);
      default: off = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
    endcase
    if (op <= OP_NAND) last_dest = rd;
    else if (op <= OP_LW || op == OP_JALR) last_dest = rt;
    return {4'($urandom_range(0, 15)), op, rs, rt, (op <= OP_NAND) ? {rd, off[11:0]} : off};
  endfunction

  // Receiver: random stall bursts, one long hold on request, none in the tail.
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{next_pc: out_next_pc, halted: out_halted,
                        illegal_op: out_illegal_op, reg_write: out_reg_write,
                        write_reg: out_write_reg, write_value: out_write_value,
                        mem_write: out_mem_write, mem_address: out_mem_address,
                        op_count: out_op_count, executed_count: out_executed_count});
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Directed program: field extremes, every opcode but halt, overflow, signed compares,
  // address wrap, load/store right after its base is written, both branch
  // outcomes, jalr with rs equal to rt, writes to register 0, illegal opcodes.
  logic [31:0] directed [] = '{
    32'h0000_0000,  // add r0, r0, r0
    32'h0801_FFFF,  // lui r1, 0xFFFF
    32'h0711_FFFF,  // ori r1 -> all ones
    32'h0802_7FFF,  // lui r2, 0x7FFF
    32'h0722_FFFF,  // ori r2 -> max positive
    32'hF012_3000,  // add r3 = r1 + r2, top bits set
    32'h0101_4000,  // sub r4 = r0 - r1
    32'h0212_5000,  // slt r5 = (-1 < max)
    32'h0221_6000,  // slt r6 = (max < -1)
    32'h0312_7000,  // or r7
    32'h0411_8000,  // nand r8
    32'h0619_FFFF,  // slti r9 = (-1 < 0xFFFF)
    32'h062A_0000,  // slti r10 = (max < 0)
    32'h0A01_FFFF,  // sw r1 at 0xFFFF, wraps
    32'h090B_00FF,  // lw r11 from 0xFF
    32'h050C_0005,  // addi r12 = 5
    32'h09CD_00FA,  // lw r13 based on r12 just written
    32'h05CC_0001,  // addi r12 += 1
    32'h0ACD_0000,  // sw r13 based on r12 just written
    32'h0B11_0003,  // beq taken
    32'h0B01_FFFF,  // beq not taken
    32'h0C55_0000,  // jalr with rs == rt
    32'h0C1E_0000,  // jalr to all ones
    32'h0D00_FFFF,  // j 0xFFFF
    32'hFFFF_FFFF,  // illegal, every bit set
    32'h0F00_0000,  // illegal
    32'h0510_0000   // addi r0 = r1
  };

  initial begin
    sb                  = new();
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_instruction_word = '0;
    quiet_tail          = 1'b0;
    hold_req            = 1'b0;
    words_sent          = 0;
    idle_cycles         = 0;
    last_dest           = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if ($urandom_range(0, 3) == 0) pause_input($urandom_range(1, 18));
      send_word(directed[i]);
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 250) hold_req = 1'b1;
      if (i == 450) begin
        // Let the pipeline empty completely before going on.
        pause_input(1);
        while (sb.pending() > 0) @(posedge clk);
      end
      if (i == RANDOM_WORDS - 100) quiet_tail = 1'b1;
      if (!quiet_tail && $urandom_range(0, 7) == 0) pause_input($urandom_range(1, 18));
      send_word(random_word());
    end

    // Halt, then a few words that must all be answered with the frozen state.
    send_word({4'($urandom_range(0, 15)), OP_HALT, 24'($urandom)});
    repeat (6) send_word($urandom);
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Run covered %0d instruction words and %0d checked results, %0d mismatches.",
             words_sent, sb.checked, sb.mismatches);
    $display("It included a long output hold, a full drain pause and words after halt.");
    if (sb.mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mie_pkg.sv
rtl/mini_isa_instruction_executor.sv
verif/tb.sv
